// ----- rtl/isma_pkg.sv -----
package isma_pkg;

	// Default sizes handed to the top level parameters.
	localparam int MAX_WINDOW_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths.
	localparam int WL_W       = 5;
	localparam int TIME_W     = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	// Register values after reset.
	localparam logic [WL_W-1:0]   WL_RESET       = 5'd10;
	localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd5000;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH   = 1'b0,
		REG_SAMPLE_INTERVAL = 1'b1
	} cfg_reg_t;

	// Action codes of an input transaction.
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_FILL   = 1'b1;

	// Strobes from the sequencer to the sample ring.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic fill_en;
	} ring_ctl_t;

endpackage

// ----- rtl/isma_ring.sv -----
module isma_ring #(
	parameter int MAX_WINDOW  = isma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = isma_pkg::SAMPLE_BITS_DEF,
	parameter int AW          = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  isma_pkg::ring_ctl_t           ctl,
	input  logic [AW-1:0]                 rd_addr,
	input  logic [AW-1:0]                 wr_addr,
	input  logic signed [SAMPLE_BITS-1:0] wr_data,
	input  logic signed [SAMPLE_BITS-1:0] fill_data,
	output logic signed [SAMPLE_BITS-1:0] rd_data
);
	import isma_pkg::*;

	logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] mem_rd_q;
	logic signed [SAMPLE_BITS-1:0] fill_q;
	logic [MAX_WINDOW-1:0]         valid_q;
	logic                          vld_rd_q;

	// Storage array with a registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// An entry that has not been written since the last fill reads as the fill value.
	// Reset behaves as a fill with zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			fill_q   <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (ctl.fill_en) begin
				valid_q <= '0;
				fill_q  <= fill_data;
			end else if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				vld_rd_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : fill_q;

endmodule

// ----- rtl/isma_div.sv -----
module isma_div #(
	parameter int SUM_W       = 21,
	parameter int LEN_W       = 5,
	parameter int SAMPLE_BITS = isma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SUM_W-1:0]       dividend,
	input  logic [LEN_W-1:0]              divisor,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] quotient
);
	import isma_pkg::*;

	localparam int CNT_W = $clog2(SUM_W + 1);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_FIN  = 3'b100
	} div_state_t;

	div_state_t       state_q;
	logic [SUM_W-1:0] dvd_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [SUM_W-1:0] mag;
	logic [LEN_W:0]   trial;
	logic [LEN_W:0]   trial_sub;
	logic             fits;

	// Magnitude of the dividend; the most negative sum still fits unsigned.
	assign mag = dividend[SUM_W-1] ? ($unsigned(~dividend) + 1'b1) : $unsigned(dividend);

	// One restoring step: shift in the next dividend bit and try the subtraction.
	assign trial     = {rem_q, dvd_q[SUM_W-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign fits      = (trial >= {1'b0, dsr_q});

	// Quotient bits gather in the low end of the dividend shifter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			dvd_q   <= '0;
			rem_q   <= '0;
			dsr_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						dvd_q   <= mag;
						neg_q   <= dividend[SUM_W-1];
						rem_q   <= '0;
						dsr_q   <= divisor;
						cnt_q   <= CNT_W'(SUM_W);
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= fits ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
					dvd_q <= {dvd_q[SUM_W-2:0], fits};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	// Truncation toward zero: divide magnitudes, then restore the sign.
	assign done     = (state_q == D_FIN);
	assign quotient = neg_q ? $signed(~dvd_q[SAMPLE_BITS-1:0] + 1'b1)
	                        : $signed(dvd_q[SAMPLE_BITS-1:0]);

endmodule

// ----- rtl/interval_sampled_moving_average.sv -----
// A transaction is accepted in idle, then passes through the decide state, the ring update
// (taken sample) or fill, the divider start, the serial divide and the output state before
// it loads the result register; a sample that is not yet due skips the ring update. The
// serial divider produces one quotient bit a cycle. The block works on one transaction at a
// time and takes the next in the cycle after the result loads. A window length write stalls
// the input while the sum is recomputed. Asynchronous reset clears ring, sum and due time.
module interval_sampled_moving_average #(
	parameter int MAX_WINDOW  = isma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = isma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	input  logic [isma_pkg::TIME_W-1:0]       now_time,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              accepted,
	output logic signed [SAMPLE_BITS-1:0]     latest_value,
	output logic signed [SAMPLE_BITS-1:0]     window_average,
	input  logic                              cfg_we,
	input  logic [isma_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [isma_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import isma_pkg::*;

	localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = SAMPLE_BITS + LEN_W;
	localparam int PRD_W = SAMPLE_BITS + LEN_W + 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_READ   = 8'b0000_0100,
		S_FILL   = 8'b0000_1000,
		S_DIVGO  = 8'b0001_0000,
		S_DIV    = 8'b0010_0000,
		S_OUT    = 8'b0100_0000,
		S_RESUM  = 8'b1000_0000
	} seq_state_t;

	seq_state_t                    state_q;
	logic [WL_W-1:0]               wl_q;
	logic [TIME_W-1:0]             int_q;
	logic                          act_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic [TIME_W-1:0]             now_q;
	logic [TIME_W-1:0]             due_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [AW-1:0]                 wp_q;
	logic signed [SAMPLE_BITS-1:0] latest_q;
	logic                          acc_q;
	logic signed [SAMPLE_BITS-1:0] avg_q;
	logic [LEN_W-1:0]              rs_idx_q;
	logic                          rs_pend_q;
	logic                          out_valid_q;
	logic                          acc_out_q;
	logic signed [SAMPLE_BITS-1:0] lat_out_q;
	logic signed [SAMPLE_BITS-1:0] avg_out_q;

	logic [LEN_W-1:0]              len;
	logic [LEN_W-1:0]              len_new;
	logic [TIME_W-1:0]             diff;
	logic signed [PRD_W-1:0]       prod;
	logic                          wl_wr;
	logic                          rs_more;
	ring_ctl_t                     ring_ctl;
	logic [AW-1:0]                 ring_rd_addr;
	logic signed [SAMPLE_BITS-1:0] ring_rd_data;
	logic                          div_start;
	logic                          div_done;
	logic signed [SAMPLE_BITS-1:0] div_q;

	// Active window length: zero counts as one, anything above the ring size as the ring size.
	function automatic logic [LEN_W-1:0] clamp_len(input logic [WL_W-1:0] w);
		logic [LEN_W-1:0] r;
		if (w == '0) begin
			r = LEN_W'(1);
		end else if (32'(w) > 32'(MAX_WINDOW)) begin
			r = LEN_W'(MAX_WINDOW);
		end else begin
			r = LEN_W'(w);
		end
		return r;
	endfunction

	assign len     = clamp_len(wl_q);
	assign len_new = clamp_len(cfg_data[WL_W-1:0]);
	assign wl_wr   = cfg_we && (cfg_index == REG_WINDOW_LENGTH);
	assign rs_more = (rs_idx_q < len);

	// Due test on the wrap-around difference, and the fill product.
	assign diff = now_q - due_q;
	assign prod = smp_q * $signed({1'b0, len});

	// Ring strobes and read address.
	always_comb begin
		ring_ctl         = '0;
		ring_ctl.rd_en   = ((state_q == S_DECIDE) && (act_q == ACT_SAMPLE) && !diff[TIME_W-1])
		                   || ((state_q == S_RESUM) && rs_more && !wl_wr);
		ring_ctl.wr_en   = (state_q == S_READ);
		ring_ctl.fill_en = (state_q == S_FILL);
		ring_rd_addr     = (state_q == S_RESUM) ? rs_idx_q[AW-1:0] : wp_q;
	end

	assign div_start = (state_q == S_DIVGO);

	isma_ring #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS),
		.AW         (AW)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ring_ctl),
		.rd_addr  (ring_rd_addr),
		.wr_addr  (wp_q),
		.wr_data  (smp_q),
		.fill_data(smp_q),
		.rd_data  (ring_rd_data)
	);

	isma_div #(
		.SUM_W      (SUM_W),
		.LEN_W      (LEN_W),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (len),
		.done    (div_done),
		.quotient(div_q)
	);

	// Sequencer and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wl_q      <= WL_RESET;
			int_q     <= INTERVAL_RESET;
			act_q     <= ACT_SAMPLE;
			smp_q     <= '0;
			now_q     <= '0;
			due_q     <= '0;
			sum_q     <= '0;
			wp_q      <= '0;
			latest_q  <= '0;
			acc_q     <= 1'b0;
			avg_q     <= '0;
			rs_idx_q  <= '0;
			rs_pend_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == REG_SAMPLE_INTERVAL)) begin
				int_q <= cfg_data[TIME_W-1:0];
			end
			if (wl_wr) begin
				// New window length: keep the ring, recompute the sum over the new span.
				wl_q      <= cfg_data[WL_W-1:0];
				sum_q     <= '0;
				rs_idx_q  <= '0;
				rs_pend_q <= 1'b0;
				state_q   <= S_RESUM;
				if (LEN_W'(wp_q) >= len_new) begin
					wp_q <= '0;
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							act_q   <= action;
							smp_q   <= sample;
							now_q   <= now_time;
							state_q <= S_DECIDE;
						end
					end
					S_DECIDE: begin
						acc_q <= 1'b0;
						if (act_q == ACT_FILL) begin
							state_q <= S_FILL;
						end else if (!diff[TIME_W-1]) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_DIVGO;
						end
					end
					S_READ: begin
						// The old entry arrives from the ring; replace it in the sum.
						sum_q    <= sum_q + SUM_W'(smp_q) - SUM_W'(ring_rd_data);
						latest_q <= smp_q;
						acc_q    <= 1'b1;
						due_q    <= due_q + int_q;
						if (LEN_W'(wp_q) + LEN_W'(1) >= len) begin
							wp_q <= '0;
						end else begin
							wp_q <= wp_q + 1'b1;
						end
						state_q <= S_DIVGO;
					end
					S_FILL: begin
						sum_q   <= prod[SUM_W-1:0];
						due_q   <= now_q + int_q;
						state_q <= S_DIVGO;
					end
					S_DIVGO: begin
						state_q <= S_DIV;
					end
					S_DIV: begin
						if (div_done) begin
							avg_q   <= div_q;
							state_q <= S_OUT;
						end
					end
					S_OUT: begin
						if (!out_valid_q || !out_stall) begin
							state_q <= S_IDLE;
						end
					end
					S_RESUM: begin
						// Reads are issued one entry a cycle; each lands in the next cycle.
						if (rs_pend_q) begin
							sum_q <= sum_q + SUM_W'(ring_rd_data);
						end
						if (rs_more) begin
							rs_idx_q  <= rs_idx_q + 1'b1;
							rs_pend_q <= 1'b1;
						end else begin
							rs_pend_q <= 1'b0;
							if (!rs_pend_q) begin
								state_q <= S_IDLE;
							end
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	// Result register; it holds a transaction until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && (!out_valid_q || !out_stall)) begin
			acc_out_q <= acc_q;
			lat_out_q <= latest_q;
			avg_out_q <= avg_q;
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign accepted       = acc_out_q;
	assign latest_value   = lat_out_q;
	assign window_average = avg_out_q;

endmodule

// ----- rtl/isma_checker.sv -----
module isma_checker #(
	parameter int SAMPLE_BITS = isma_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          action,
	input logic signed [SAMPLE_BITS-1:0] sample,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          accepted,
	input logic signed [SAMPLE_BITS-1:0] latest_value,
	input logic signed [SAMPLE_BITS-1:0] window_average
);
	import isma_pkg::*;

	logic                          act_work_q;
	logic signed [SAMPLE_BITS-1:0] smp_work_q;
	logic                          act_seen_q;
	logic signed [SAMPLE_BITS-1:0] smp_seen_q;
	logic signed [SAMPLE_BITS-1:0] last_latest_q;

	// The transaction in work, and the one whose result the output register shows.
	// A new input may be taken while an earlier result still waits, so the result
	// takes its input record only when the output register is free to load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_work_q    <= ACT_SAMPLE;
			smp_work_q    <= '0;
			act_seen_q    <= ACT_SAMPLE;
			smp_seen_q    <= '0;
			last_latest_q <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				act_work_q <= action;
				smp_work_q <= sample;
			end
			if (!out_valid || !out_stall) begin
				act_seen_q <= act_work_q;
				smp_seen_q <= smp_work_q;
			end
			if (out_valid && !out_stall) begin
				last_latest_q <= latest_value;
			end
		end
	end

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(accepted)
			&& $stable(latest_value) && $stable(window_average))
		else $error("stalled result changed");

	// Only one transaction is in work at a time.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in work");

	// A fill never reports a taken sample.
	a_fill_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (act_seen_q == ACT_FILL) |-> !accepted)
		else $error("fill reported as a taken sample");

	// A taken sample becomes the latest value; otherwise the latest value stands.
	a_latest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accepted ? (latest_value == smp_seen_q)
		                        : (latest_value == last_latest_q)))
		else $error("latest value does not follow the taken samples");

endmodule

bind interval_sampled_moving_average isma_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_isma_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.action        (action),
	.sample        (sample),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.accepted      (accepted),
	.latest_value  (latest_value),
	.window_average(window_average)
);
